### rtl/trct_pkg.sv
package trct_pkg;

    // Field widths
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned IRQ_W  = 3;
    localparam int unsigned UNITS  = 3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HBLANK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_VBLANK = 3'd4;

    // Register offsets inside one unit's window
    localparam logic [1:0] REG_COUNT   = 2'd0;
    localparam logic [1:0] REG_CONTROL = 2'd1;
    localparam logic [1:0] REG_COMPARE = 2'd2;

    // Prescaler step and period per unit
    localparam logic [DATA_W-1:0] STEP_U0   = 16'd11;
    localparam logic [DATA_W-1:0] STEP_U1   = 16'd11;
    localparam logic [DATA_W-1:0] STEP_U2   = 16'd1;
    localparam logic [DATA_W-1:0] PERIOD_U0 = 16'(7 * 4);
    localparam logic [DATA_W-1:0] PERIOD_U1 = 16'(7 * 3413);
    localparam logic [DATA_W-1:0] PERIOD_U2 = 16'd8;

    // Operation handed from the input stage to every timer unit
    typedef struct packed {
        logic              fire;
        logic [CMD_W-1:0]  cmd;
        logic [1:0]        unit_sel;
        logic [1:0]        reg_sel;
        logic [DATA_W-1:0] data;
        logic              level;
    } t_trct_op;

    // What one unit returns for the current operation
    typedef struct packed {
        logic [DATA_W-1:0] rd_data;
        logic              irq;
    } t_trct_res;

    function automatic logic [DATA_W-1:0] step_of(input logic [1:0] unit);
        logic [DATA_W-1:0] s;
        case (unit)
            2'd0:    s = STEP_U0;
            2'd1:    s = STEP_U1;
            default: s = STEP_U2;
        endcase
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] period_of(input logic [1:0] unit);
        logic [DATA_W-1:0] p;
        case (unit)
            2'd0:    p = PERIOD_U0;
            2'd1:    p = PERIOD_U1;
            default: p = PERIOD_U2;
        endcase
        return p;
    endfunction

    // Gate decode: 0 runs while blank low, 1 always, 2 while blank high, 3 never
    function automatic logic gate_decode(input logic [1:0] mode, input logic level);
        logic g;
        case (mode)
            2'd0:    g = ~level;
            2'd1:    g = 1'b1;
            2'd2:    g = level;
            default: g = 1'b0;
        endcase
        return g;
    endfunction

endpackage

### rtl/trct_if.sv
interface trct_in_if import trct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  register_index;
    logic [DATA_W-1:0] write_data;
    logic              blank_level;

    modport source (output valid, command, register_index, write_data, blank_level,
                    input ready);
    modport sink   (input valid, command, register_index, write_data, blank_level,
                    output ready);
endinterface

interface trct_out_if import trct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_pulses;

    modport source (output valid, read_data, irq_pulses, input ready);
    modport sink   (input valid, read_data, irq_pulses, output ready);
endinterface

### rtl/triple_root_counter_timer_top.sv
// Throughput: one beat per cycle while o_out.ready does not stall the result stage;
// the input register and result register form a two-stage pipe, and timer state
// updates as a beat leaves the input stage.
// Reset (i_rst_n, synchronous, active low): counters, compares and controls
// clear, prescaler credits load their periods, both pipe stages empty.
module triple_root_counter_timer_top import trct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    trct_in_if.sink     i_in,
    trct_out_if.source  o_out
);

    logic              r_in_vld;
    logic [CMD_W-1:0]  r_cmd;
    logic [IDX_W-1:0]  r_idx;
    logic [DATA_W-1:0] r_data;
    logic              r_level;

    logic              r_out_vld;
    logic [DATA_W-1:0] r_rd_data;
    logic [IRQ_W-1:0]  r_irq;

    logic              r_hblank, n_hblank;
    logic              r_vblank, n_vblank;

    logic              out_take;
    logic              in_adv;
    t_trct_op          op;
    t_trct_res         res [UNITS];
    logic [DATA_W-1:0] rd_or;
    logic [IRQ_W-1:0]  irq_vec;

    // Pipe handshake
    assign out_take   = !r_out_vld || o_out.ready;
    assign in_adv     = r_in_vld && out_take;
    assign i_in.ready = !r_in_vld || out_take;

    assign op.fire     = in_adv;
    assign op.cmd      = r_cmd;
    assign op.unit_sel = r_idx[3:2];
    assign op.reg_sel  = r_idx[1:0];
    assign op.data     = r_data;
    assign op.level    = r_level;

    // Timer units
    trct_unit #(.UNIT_ID(0)) u_unit0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op),
        .i_blank_now(r_hblank), .o_res(res[0])
    );
    trct_unit #(.UNIT_ID(1)) u_unit1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op),
        .i_blank_now(r_vblank), .o_res(res[1])
    );
    trct_unit #(.UNIT_ID(2)) u_unit2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op),
        .i_blank_now(1'b1), .o_res(res[2])
    );

    // Only the selected unit drives nonzero read data
    assign rd_or   = res[0].rd_data | res[1].rd_data | res[2].rd_data;
    assign irq_vec = {res[2].irq, res[1].irq, res[0].irq};

    // Blank levels
    always_comb begin
        n_hblank = r_hblank;
        n_vblank = r_vblank;
        if (in_adv && r_cmd == CMD_HBLANK) begin
            n_hblank = r_level;
        end
        if (in_adv && r_cmd == CMD_VBLANK) begin
            n_vblank = r_level;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_hblank  <= 1'b0;
            r_vblank  <= 1'b0;
        end else begin
            r_hblank <= n_hblank;
            r_vblank <= n_vblank;
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (out_take) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd   <= i_in.command;
            r_idx   <= i_in.register_index;
            r_data  <= i_in.write_data;
            r_level <= i_in.blank_level;
        end
    end

    // Result stage payload
    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_rd_data <= rd_or;
            r_irq     <= irq_vec;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.read_data  = r_rd_data;
    assign o_out.irq_pulses = r_irq;

endmodule

### rtl/trct_unit.sv
module trct_unit import trct_pkg::*; #(
    parameter int unsigned UNIT_ID = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_trct_op  i_op,
    input  logic      i_blank_now,
    output t_trct_res o_res
);

    localparam logic [1:0]        UID    = UNIT_ID[1:0];
    localparam logic [DATA_W-1:0] STEP   = step_of(UID);
    localparam logic [DATA_W-1:0] PERIOD = period_of(UID);
    localparam int unsigned       PE_BIT = (UNIT_ID == 2) ? 9 : 8;

    typedef struct packed {
        logic armed;
        logic line;
        logic pulse;
    } t_irq_st;

    // One interrupt event: only while armed; toggle mode may swallow the pulse
    function automatic t_irq_st irq_event(input t_irq_st s, input logic ev,
                                          input logic rpt, input logic tgl);
        t_irq_st r;
        r = s;
        if (ev && s.armed) begin
            r.armed = rpt;
            if (tgl && !s.line) begin
                r.line = 1'b1;
            end else begin
                r.line  = 1'b0;
                r.pulse = 1'b1;
            end
        end
        return r;
    endfunction

    logic [DATA_W-1:0] r_count,  n_count;
    logic [DATA_W-1:0] r_cmp,    n_cmp;
    logic [DATA_W-1:0] r_credit, n_credit;
    logic              r_sync_en, n_sync_en;
    logic [1:0]        r_sync_mode, n_sync_mode;
    logic              r_roc, n_roc;
    logic              r_cmp_irq_en, n_cmp_irq_en;
    logic              r_wrap_irq_en, n_wrap_irq_en;
    logic              r_repeat, n_repeat;
    logic              r_toggle, n_toggle;
    logic              r_pre_en, n_pre_en;
    logic              r_armed, n_armed;
    logic              r_line, n_line;
    logic              r_cmp_hit, n_cmp_hit;
    logic              r_wrap_hit, n_wrap_hit;
    logic              r_gate, n_gate;

    logic              sel;
    logic              credit_out;
    logic              adv;
    logic [DATA_W-1:0] cnt_inc;
    logic              wrap_ev;
    logic              cmp_ev;
    t_irq_st           irq_a, irq_b, irq_c;
    logic [DATA_W-1:0] ctrl_word;

    assign sel        = (i_op.unit_sel == UID);
    assign credit_out = (r_credit <= STEP);
    assign adv        = (!r_pre_en || credit_out) && r_gate;
    assign cnt_inc    = r_count + 16'd1;
    assign wrap_ev    = (cnt_inc == '0);
    assign cmp_ev     = (cnt_inc == r_cmp);

    // Interrupts from wrap first, then from compare
    assign irq_a = '{armed: r_armed, line: r_line, pulse: 1'b0};
    assign irq_b = irq_event(irq_a, wrap_ev && r_wrap_irq_en, r_repeat, r_toggle);
    assign irq_c = irq_event(irq_b, cmp_ev && r_cmp_irq_en, r_repeat, r_toggle);

    assign ctrl_word = {3'b000, r_wrap_hit, r_cmp_hit, r_line, 1'b0, r_pre_en,
                        r_toggle, r_repeat, r_wrap_irq_en, r_cmp_irq_en, r_roc,
                        r_sync_mode, r_sync_en};

    // Next state for the operation in the input stage
    always_comb begin
        n_count       = r_count;
        n_cmp         = r_cmp;
        n_credit      = r_credit;
        n_sync_en     = r_sync_en;
        n_sync_mode   = r_sync_mode;
        n_roc         = r_roc;
        n_cmp_irq_en  = r_cmp_irq_en;
        n_wrap_irq_en = r_wrap_irq_en;
        n_repeat      = r_repeat;
        n_toggle      = r_toggle;
        n_pre_en      = r_pre_en;
        n_armed       = r_armed;
        n_line        = r_line;
        n_cmp_hit     = r_cmp_hit;
        n_wrap_hit    = r_wrap_hit;
        n_gate        = r_gate;
        o_res.rd_data = '0;
        o_res.irq     = 1'b0;
        if (i_op.fire) begin
            case (i_op.cmd)
                CMD_TICK: begin
                    if (r_pre_en) begin
                        n_credit = credit_out ? (r_credit + (PERIOD - STEP))
                                              : (r_credit - STEP);
                    end
                    if (adv) begin
                        n_count    = (cmp_ev && r_roc) ? '0 : cnt_inc;
                        n_wrap_hit = r_wrap_hit | wrap_ev;
                        n_cmp_hit  = r_cmp_hit | cmp_ev;
                        n_armed    = irq_c.armed;
                        n_line     = irq_c.line;
                        o_res.irq  = irq_c.pulse;
                    end
                end
                CMD_READ: begin
                    if (sel) begin
                        case (i_op.reg_sel)
                            REG_COUNT:   o_res.rd_data = r_count;
                            REG_CONTROL: begin
                                o_res.rd_data = ctrl_word;
                                n_cmp_hit     = 1'b0;
                                n_wrap_hit    = 1'b0;
                            end
                            REG_COMPARE: o_res.rd_data = r_cmp;
                            default:     o_res.rd_data = '0;
                        endcase
                    end
                end
                CMD_WRITE: begin
                    if (sel) begin
                        case (i_op.reg_sel)
                            REG_COUNT:   n_count = i_op.data;
                            REG_CONTROL: begin
                                n_count       = '0;
                                n_armed       = 1'b1;
                                n_line        = 1'b1;
                                n_sync_en     = i_op.data[0];
                                n_sync_mode   = i_op.data[2:1];
                                n_roc         = i_op.data[3];
                                n_cmp_irq_en  = i_op.data[4];
                                n_wrap_irq_en = i_op.data[5];
                                n_repeat      = i_op.data[6];
                                n_toggle      = i_op.data[7];
                                n_pre_en      = i_op.data[PE_BIT];
                                n_gate        = i_op.data[0]
                                              ? gate_decode(i_op.data[2:1], i_blank_now)
                                              : 1'b1;
                            end
                            REG_COMPARE: n_cmp = i_op.data;
                            default:     n_cmp = r_cmp;
                        endcase
                    end
                end
                CMD_HBLANK: begin
                    if (UNIT_ID == 0 && r_sync_en) begin
                        n_gate = gate_decode(r_sync_mode, i_op.level);
                    end
                end
                CMD_VBLANK: begin
                    if (UNIT_ID == 1 && r_sync_en) begin
                        n_gate = gate_decode(r_sync_mode, i_op.level);
                    end
                end
                default: begin
                    n_gate = r_gate;
                end
            endcase
        end
    end

    // Timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_cmp         <= '0;
            r_credit      <= PERIOD;
            r_sync_en     <= 1'b0;
            r_sync_mode   <= '0;
            r_roc         <= 1'b0;
            r_cmp_irq_en  <= 1'b0;
            r_wrap_irq_en <= 1'b0;
            r_repeat      <= 1'b0;
            r_toggle      <= 1'b0;
            r_pre_en      <= 1'b0;
            r_armed       <= 1'b0;
            r_line        <= 1'b0;
            r_cmp_hit     <= 1'b0;
            r_wrap_hit    <= 1'b0;
            r_gate        <= 1'b0;
        end else begin
            r_count       <= n_count;
            r_cmp         <= n_cmp;
            r_credit      <= n_credit;
            r_sync_en     <= n_sync_en;
            r_sync_mode   <= n_sync_mode;
            r_roc         <= n_roc;
            r_cmp_irq_en  <= n_cmp_irq_en;
            r_wrap_irq_en <= n_wrap_irq_en;
            r_repeat      <= n_repeat;
            r_toggle      <= n_toggle;
            r_pre_en      <= n_pre_en;
            r_armed       <= n_armed;
            r_line        <= n_line;
            r_cmp_hit     <= n_cmp_hit;
            r_wrap_hit    <= n_wrap_hit;
            r_gate        <= n_gate;
        end
    end

endmodule
